// ===== rtl/mbrh_pkg.sv =====
package mbrh_pkg;

  localparam int MaxLen     = 1024;
  localparam int MaxBases   = 4;
  localparam int NumStrings = 2;
  localparam int HashW      = 30;
  localparam int LenW       = 11;
  localparam int IdxW       = 10;
  localparam int BaseW      = 2;
  localparam int StrW       = 1;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 30;

  localparam logic [HashW-1:0] ModulusReset = 30'd1000000007;
  localparam logic [HashW-1:0] BaseReset0   = 30'd256;
  localparam logic [HashW-1:0] BaseReset1   = 30'd257;
  localparam logic [HashW-1:0] BaseReset2   = 30'd258;
  localparam logic [HashW-1:0] BaseReset3   = 30'd259;
  localparam logic [2:0]       BasesReset   = 3'd4;

  localparam logic [CfgIdxW-1:0] RegModulus = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBase0   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBase1   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBase2   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBase3   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBases   = 3'd5;

  localparam logic [1:0] CmdClear   = 2'd0;
  localparam logic [1:0] CmdAppend  = 2'd1;
  localparam logic [1:0] CmdHash    = 2'd2;
  localparam logic [1:0] CmdCompare = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StPowRd,
    StPowMul,
    StPowWr,
    StAppRd,
    StAppMul,
    StAppWr,
    StQRd,
    StQMul,
    StQSub,
    StDone
  } state_t;

  // Request into the shared modular multiply unit.
  typedef struct packed {
    logic             start;
    logic [HashW-1:0] a;
    logic [HashW-1:0] b;
    logic [HashW-1:0] c;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [HashW-1:0] r;
  } mul_rsp_t;

endpackage

// ===== rtl/mbrh_if.sv =====
interface mbrh_cmd_if;
  import mbrh_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic             first_string;
  logic             second_string;
  logic [7:0]       byte_value;
  logic [LenW-1:0]  first_start;
  logic [LenW-1:0]  second_start;
  logic [LenW-1:0]  span_length;
  modport source (output valid, command, first_string, second_string, byte_value,
                  first_start, second_start, span_length, input ready);
  modport sink (input valid, command, first_string, second_string, byte_value,
                first_start, second_start, span_length, output ready);
endinterface

interface mbrh_res_if;
  import mbrh_pkg::*;
  logic             valid;
  logic             ready;
  logic [HashW-1:0] hash_zero;
  logic [HashW-1:0] hash_one;
  logic [HashW-1:0] hash_two;
  logic [HashW-1:0] hash_three;
  logic             equal;
  logic             range_error;
  logic [LenW-1:0]  current_length;
  modport source (output valid, hash_zero, hash_one, hash_two, hash_three, equal,
                  range_error, current_length, input ready);
  modport sink (input valid, hash_zero, hash_one, hash_two, hash_three, equal,
                range_error, current_length, output ready);
endinterface

interface mbrh_cfg_if;
  import mbrh_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mbrh_ram.sv =====
module mbrh_ram #(
  parameter int Depth = 1024,
  parameter int Width = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mbrh_mulmod.sv =====
module mbrh_mulmod
  import mbrh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic [HashW-1:0] modulus,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  // Computes (a*b + c) mod m with a and c below m (m of zero means 2^30); b may
  // be any 30-bit value, since every step keeps the accumulator reduced. The
  // product is built by shift-and-add over b, two bits per cycle, and done is
  // raised together with the final step's result.
  localparam int Steps = HashW / 2;

  logic [HashW:0]   m_eff;
  logic [HashW-1:0] acc;
  logic [HashW-1:0] a_reg;
  logic [HashW-1:0] b_reg;
  logic [HashW-1:0] c_reg;
  logic [3:0]       cnt;
  logic             busy;
  logic             done_r;
  logic [HashW+2:0] t0, t1, t2, t3;
  logic [HashW-1:0] d0, d1;
  logic [HashW+2:0] fin;

  assign m_eff = (modulus == '0) ? {1'b1, {HashW{1'b0}}} : {1'b0, modulus};

  function automatic logic [HashW-1:0] red2(input logic [HashW+2:0] v,
                                            input logic [HashW:0] m);
    logic [HashW+2:0] mm;
    logic [HashW+2:0] w;
    begin
      mm = {2'b00, m};
      w  = v;
      if (w >= mm) w = w - mm;
      red2 = w[HashW-1:0];
    end
  endfunction

  // acc*2 + bit*a, reduced, twice per cycle.
  always_comb begin
    t0 = {2'b00, acc, 1'b0};
    d0 = red2(t0, m_eff);
    t1 = {3'b000, d0} + (b_reg[HashW-1] ? {3'b000, a_reg} : '0);
    t1 = {3'b000, red2(t1, m_eff)};
    t2 = {2'b00, t1[HashW-1:0], 1'b0};
    d1 = red2(t2, m_eff);
    t3 = {3'b000, d1} + (b_reg[HashW-2] ? {3'b000, a_reg} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        acc   <= '0;
        a_reg <= req.a;
        b_reg <= req.b;
        c_reg <= req.c;
      end else if (busy) begin
        acc   <= red2(t3, m_eff);
        b_reg <= {b_reg[HashW-3:0], 2'b00};
        cnt   <= cnt + 4'd1;
        if (cnt == 4'(Steps - 1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The addend c is folded in once the product is complete.
  assign fin = {3'b000, acc} + {3'b000, c_reg};
  assign rsp = '{done: done_r, r: red2(fin, m_eff)};

endmodule

// ===== rtl/multi_base_rolling_hash_compare_core.sv =====
// Multi-base polynomial rolling hash engine.
// Commands arrive on the cmd channel (valid/ready), one result leaves on the
// res channel per command; cfg is a separate write channel for modulus, the
// four bases and the active base count. Any modulus or base write empties
// both strings and the power table. Configuration is taken only while the
// block is idle with no result waiting.
// Each string is kept as prefix hashes in one prefix memory, and powers of
// each base in a power memory, both synchronous RAMs with one read port.
// Every modular product goes through one shared shift-add multiply unit.
// Clear, and an append to a full string, go straight to the result. An
// append first makes a new power of each base when the power table is
// too short, then updates all four bases; hash and compare work through
// the active bases in turn; an out-of-range query ends at the range check.
// One command is worked on at a time, so with a ready receiver the next
// command is taken once the result has been taken. The output register
// holds the result until the receiver takes it, and the block accepts no
// command meanwhile.
// Reset (rst, synchronous) restores the register defaults and empties both
// strings; the memories are not cleared, since nothing unwritten is read.
module multi_base_rolling_hash_compare_core
  import mbrh_pkg::*;
(
  input logic    clk,
  input logic    rst,
  mbrh_cmd_if.sink   cmd,
  mbrh_res_if.source res,
  mbrh_cfg_if.sink   cfg
);

  localparam int PrefAw = StrW + BaseW + LenW;
  localparam int PowAw  = BaseW + LenW;

  logic [HashW-1:0] modulus;
  logic [HashW-1:0] base_reg [4];
  logic [2:0]       bases_in_use;
  logic [LenW-1:0]  str_len [NumStrings];
  logic [LenW-1:0]  powers_filled;

  state_t state, state_next;

  // Latched command.
  logic [1:0]      c_cmd;
  logic            c_sa, c_sb;
  logic [7:0]      c_byte;
  logic [LenW-1:0] c_st0, c_st1, c_len;

  logic [BaseW-1:0] k;
  logic [2:0]       step;
  logic [1:0]       nb_m1;
  logic [HashW-1:0] op_a, op_b, op_c, hval;
  logic             eq_acc, err_r;
  logic [HashW-1:0] h_r [4];
  logic             mul_go;

  // Memories.
  logic               p_we, w_we;
  logic [PrefAw-1:0]  p_waddr, p_raddr;
  logic [HashW-1:0]   p_wdata, p_rdata;
  logic [PowAw-1:0]   w_waddr, w_raddr;
  logic [HashW-1:0]   w_wdata, w_rdata;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  mbrh_ram #(.Depth(1 << PrefAw), .Width(HashW)) u_pref (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata));

  mbrh_ram #(.Depth(1 << PowAw), .Width(HashW)) u_pow (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata));

  mbrh_mulmod u_mul (.clk(clk), .rst(rst), .modulus(modulus), .req(mreq), .rsp(mrsp));

  logic [HashW:0] m_eff;
  assign m_eff = (modulus == '0) ? {1'b1, {HashW{1'b0}}} : {1'b0, modulus};

  // Modular sum of two values below the modulus.
  function automatic logic [HashW-1:0] addmod(input logic [HashW-1:0] x,
                                              input logic [HashW-1:0] y,
                                              input logic [HashW:0] m);
    logic [HashW+1:0] s;
    begin
      s = {2'b00, x} + {2'b00, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      addmod = s[HashW-1:0];
    end
  endfunction

  logic [HashW-1:0] one_mod;
  assign one_mod = (m_eff == 31'd1) ? '0 : 30'd1;

  logic a_ok, b_ok;
  logic [LenW-1:0] len_a, len_b;
  logic [LenW:0] end0, end1;
  assign a_ok  = 32'(cmd.first_string) < NumStrings;
  assign len_a = str_len[c_sa];
  assign len_b = str_len[c_sb];
  assign end0  = {1'b0, c_st0} + {1'b0, c_len};
  assign end1  = {1'b0, c_st1} + {1'b0, c_len};
  assign b_ok  = 32'(c_sb) < NumStrings;

  // Substring side: side 0 = sa, side 1 = sb.
  logic             side;
  logic [LenW-1:0]  q_start, q_end;
  logic [HashW-1:0] hi_v, lo_v, pw_v;
  logic             q_sel;
  assign q_sel   = side ? c_sb : c_sa;
  assign q_start = side ? c_st1 : c_st0;
  assign q_end   = side ? end1[LenW-1:0] : end0[LenW-1:0];

  assign cfg.ready = (state == StIdle) && !res.valid;
  assign cmd.ready = (state == StIdle) && !res.valid && !cfg.valid;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      StIdle: begin
        if (cmd.valid && cmd.ready) begin
          state_next = StDone;
          if (a_ok && cmd.command == CmdAppend &&
              str_len[cmd.first_string] < LenW'(MaxLen)) begin
            state_next = (powers_filled <= str_len[cmd.first_string]) ? StPowRd : StAppRd;
          end else if (a_ok && (cmd.command == CmdHash || cmd.command == CmdCompare)) begin
            state_next = StQRd;
          end
        end
      end
      StPowRd:  state_next = (step == 3'd1) ? StPowMul : StPowRd;
      StPowMul: state_next = mrsp.done ? StPowWr : StPowMul;
      StPowWr:  state_next = (k == BaseW'(MaxBases - 1)) ? StAppRd : StPowRd;
      StAppRd:  state_next = (step == 3'd1) ? StAppMul : StAppRd;
      StAppMul: state_next = mrsp.done ? StAppWr : StAppMul;
      StAppWr:  state_next = (k == BaseW'(MaxBases - 1)) ? StDone : StAppRd;
      StQRd:    state_next = err_r ? StDone : ((step == 3'd4) ? StQMul : StQRd);
      StQMul:   state_next = mrsp.done ? StQSub : StQMul;
      StQSub: begin
        if (c_cmd == CmdCompare && !side) state_next = StQRd;
        else if (k == nb_m1) state_next = StDone;
        else state_next = StQRd;
      end
      StDone:   state_next = StIdle;
      default:  state_next = StIdle;
    endcase
  end

  // Memory addresses and multiply requests.
  always_comb begin
    p_we    = 1'b0;
    w_we    = 1'b0;
    p_waddr = {c_sa, k, c_len};
    p_wdata = mrsp.r;
    w_waddr = {k, powers_filled + LenW'(1)};
    w_wdata = mrsp.r;
    p_raddr = {c_sa, k, len_a};
    w_raddr = {k, powers_filled};
    mreq    = '0;
    mreq.a  = op_a;
    mreq.b  = op_b;
    mreq.c  = op_c;
    case (state)
      StQRd: begin
        p_raddr = (step == 3'd0) ? {q_sel, k, q_start} : {q_sel, k, q_end};
        w_raddr = {k, c_len};
      end
      StPowWr: w_we = 1'b1;
      StAppWr: begin
        p_we    = 1'b1;
        p_waddr = {c_sa, k, len_a + LenW'(1)};
      end
      default: ;
    endcase
    // The start flag is registered along with the operands, so the request goes out with them.
    mreq.start = mul_go;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= StIdle;
      modulus       <= ModulusReset;
      base_reg[0]   <= BaseReset0;
      base_reg[1]   <= BaseReset1;
      base_reg[2]   <= BaseReset2;
      base_reg[3]   <= BaseReset3;
      bases_in_use  <= BasesReset;
      powers_filled <= '0;
      for (int i = 0; i < NumStrings; i++) str_len[i] <= '0;
      res.valid     <= 1'b0;
      step          <= '0;
      k             <= '0;
      mul_go        <= 1'b0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready) res.valid <= 1'b0;
      mul_go <= ((state == StPowRd || state == StAppRd) && step == 3'd1) ||
                (state == StQRd && step == 3'd4 && !err_r);

      // Configuration transfer.
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          RegModulus: modulus <= cfg.data;
          RegBase0:   base_reg[0] <= cfg.data;
          RegBase1:   base_reg[1] <= cfg.data;
          RegBase2:   base_reg[2] <= cfg.data;
          RegBase3:   base_reg[3] <= cfg.data;
          RegBases:   bases_in_use <= cfg.data[2:0];
          default: ;
        endcase
        if (cfg.index <= RegBase3) begin
          powers_filled <= '0;
          for (int i = 0; i < NumStrings; i++) str_len[i] <= '0;
        end
      end

      case (state)
        StIdle: begin
          if (cmd.valid && cmd.ready) begin
            c_cmd  <= cmd.command;
            c_sa   <= cmd.first_string;
            c_sb   <= cmd.second_string;
            c_byte <= cmd.byte_value;
            c_st0  <= cmd.first_start;
            c_st1  <= cmd.second_start;
            c_len  <= cmd.span_length;
            k      <= '0;
            step   <= '0;
            side   <= 1'b0;
            eq_acc <= 1'b1;
            for (int i = 0; i < 4; i++) h_r[i] <= '0;
            nb_m1  <= (bases_in_use == 3'd0) ? 2'd0 :
                      (bases_in_use > 3'(MaxBases)) ? 2'(MaxBases - 1) :
                      2'(bases_in_use - 3'd1);
            err_r  <= !a_ok ||
                      (cmd.command == CmdAppend && str_len[cmd.first_string] >= LenW'(MaxLen));
            if (a_ok && cmd.command == CmdClear) str_len[cmd.first_string] <= '0;
          end
        end
        StPowRd: begin
          // New power = previous power * base mod m.
          if (step == 3'd1) begin
            step <= '0;
            op_a <= (powers_filled == '0) ? one_mod : w_rdata;
            op_b <= base_reg[k];
            op_c <= '0;
          end else begin
            step <= step + 3'd1;
          end
        end
        StPowWr: begin
          k <= k + BaseW'(1);
          if (k == BaseW'(MaxBases - 1)) powers_filled <= powers_filled + LenW'(1);
        end
        StAppRd: begin
          if (step == 3'd1) begin
            step <= '0;
            op_a <= (len_a == '0) ? '0 : p_rdata;
            op_b <= base_reg[k];
            op_c <= {22'd0, c_byte};
          end else begin
            step <= step + 3'd1;
          end
        end
        StAppWr: begin
          k <= k + BaseW'(1);
          if (k == BaseW'(MaxBases - 1)) str_len[c_sa] <= len_a + LenW'(1);
        end
        StQRd: begin
          // Range check is done on the first visit.
          if (k == '0 && step == 3'd0 && !side) begin
            if (end0 > {1'b0, len_a} ||
                (c_cmd == CmdCompare && (!b_ok || end1 > {1'b0, len_b}))) begin
              err_r <= 1'b1;
            end
          end
          // Each entry arrives in the cycle after its address; the end entry is
          // addressed right after the start entry.
          if (step == 3'd1) begin
            lo_v <= (q_start == '0) ? '0 : p_rdata;
            pw_v <= (c_len == '0) ? one_mod : w_rdata;
          end
          if (step == 3'd2) hi_v <= (q_end == '0) ? '0 : p_rdata;
          if (step == 3'd4) begin
            step <= '0;
            op_a <= lo_v;
            op_b <= pw_v;
            op_c <= '0;
          end else begin
            step <= step + 3'd1;
          end
        end
        StQSub: begin
          // hi minus lo*power, as hi plus the negated product mod m.
          if (c_cmd == CmdCompare) begin
            if (!side) begin
              hval <= addmod(hi_v, (mrsp.r == '0) ? '0 : 30'(m_eff - 31'(mrsp.r)), m_eff);
              side <= 1'b1;
            end else begin
              if (hval != addmod(hi_v, (mrsp.r == '0) ? '0 : 30'(m_eff - 31'(mrsp.r)),
                                 m_eff)) eq_acc <= 1'b0;
              side <= 1'b0;
              k    <= k + BaseW'(1);
            end
          end else begin
            h_r[k] <= addmod(hi_v, (mrsp.r == '0) ? '0 : 30'(m_eff - 31'(mrsp.r)), m_eff);
            k      <= k + BaseW'(1);
          end
        end
        StDone: begin
          res.valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register contents.
  always_ff @(posedge clk) begin
    if (state == StDone) begin
      res.hash_zero      <= err_r ? '0 : h_r[0];
      res.hash_one       <= err_r ? '0 : h_r[1];
      res.hash_two       <= err_r ? '0 : h_r[2];
      res.hash_three     <= err_r ? '0 : h_r[3];
      res.equal          <= !err_r && (c_cmd == CmdCompare) && eq_acc;
      res.range_error    <= err_r;
      res.current_length <= (32'(c_sa) < NumStrings) ? len_a : '0;
    end
  end

endmodule

// ===== rtl/mbrh_checker.sv =====
module mbrh_checker
  import mbrh_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_equal,
  input logic res_range_error,
  input logic [LenW-1:0] res_current_length
);

  // A held result keeps its equal and range_error flags.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_equal) && $stable(res_range_error))
    else $error("result changed while stalled");

  // No new command while a result waits.
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !cmd_ready)
    else $error("command taken while result pending");

  // An error result never reports a match.
  a_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_range_error |-> !res_equal)
    else $error("equal set on error");

  // Length never exceeds capacity.
  a_len: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_current_length <= LenW'(MaxLen))
    else $error("length beyond capacity");

endmodule

bind multi_base_rolling_hash_compare_core mbrh_checker u_chk (
  .clk(clk), .rst(rst), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_equal(res.equal),
  .res_range_error(res.range_error), .res_current_length(res.current_length));
